FILE: hw/rtl/uti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uti_pkg;

	// Field widths
	localparam int PosW   = 24;
	localparam int AngW   = 16;
	localparam int CmdW   = 16;
	localparam int LimW   = 15;
	localparam int WsW    = 23;
	localparam int CfgW   = 24;
	localparam int CfgIdxW = 3;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_TIME_STEP     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TURN_LIMIT    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WS_HALF_WIDTH = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_START_X       = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_START_Y       = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_START_HEADING = 3'd6;

	// Register reset values
	localparam logic [15:0]    TimeStepRst = 16'd6554;
	localparam logic [LimW-1:0] SpeedLimRst = 15'd4096;
	localparam logic [LimW-1:0] TurnLimRst  = 15'd8192;
	localparam logic [WsW-1:0]  WsHalfRst   = 23'd327680;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_LIMIT     = 2'd1,
		ST_WORKSPACE = 2'd2,
		ST_FAILED    = 2'd3
	} status_t;

	// CORDIC, Q2.30 vectors, 2^32 = full turn on the angle
	localparam int CordicSteps = 16;
	localparam int CordicCntW  = $clog2(CordicSteps);
	localparam logic signed [31:0] CordicStart = 32'sd652032874;
	// 65536/(2*pi) in Q.16
	localparam logic signed [31:0] RadToBam    = 32'sd683565276;

	typedef struct packed {
		logic              busy;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} cordic_res_t;

	function automatic logic signed [32:0] atan_lut(input logic [CordicCntW-1:0] i);
		logic signed [32:0] r;
		case (i)
			4'd0:    r = 33'sh020000000;
			4'd1:    r = 33'sh012E4051E;
			4'd2:    r = 33'sh009FB385B;
			4'd3:    r = 33'sh0051111D4;
			4'd4:    r = 33'sh0028B0D43;
			4'd5:    r = 33'sh00145D7E1;
			4'd6:    r = 33'sh000A2F61E;
			4'd7:    r = 33'sh000517C55;
			4'd8:    r = 33'sh00028BE53;
			4'd9:    r = 33'sh000145F2F;
			4'd10:   r = 33'sh0000A2F98;
			4'd11:   r = 33'sh0000517CC;
			4'd12:   r = 33'sh000028BE6;
			4'd13:   r = 33'sh0000145F3;
			4'd14:   r = 33'sh00000A2FA;
			default: r = 33'sh00000517D;
		endcase
		return r;
	endfunction

	// Pose plus rounded delta (product >> 42, round half up), saturated to 24 bits
	function automatic logic signed [PosW-1:0] pos_step(input logic signed [PosW-1:0] pos,
			input logic signed [63:0] p);
		logic signed [PosW+1:0] sum;
		sum = $signed({{2{pos[PosW-1]}}, pos}) + $signed({{4{p[63]}}, p[63:42]})
			+ $signed({{(PosW+1){1'b0}}, p[41]});
		if (sum > $signed(26'sd8388607)) begin
			return 24'sh7FFFFF;
		end else if (sum < -$signed(26'sd8388608)) begin
			return 24'sh800000;
		end
		return sum[PosW-1:0];
	endfunction

	// |v| > lim for a command field
	function automatic logic cmd_over(input logic signed [CmdW-1:0] v,
			input logic [LimW-1:0] lim);
		logic [CmdW-1:0] mag;
		mag = v[CmdW-1] ? (~v + 16'd1) : v;
		return mag > {1'b0, lim};
	endfunction

	// |p| > lim for a position
	function automatic logic pos_over(input logic signed [PosW-1:0] p,
			input logic [WsW-1:0] lim);
		logic [PosW-1:0] mag;
		mag = p[PosW-1] ? (~p + 24'd1) : p;
		return mag > {1'b0, lim};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/uti_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface uti_cmd_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] speed;
	logic signed [15:0] turn_rate;
	logic              restart;

	modport source (output valid, output speed, output turn_rate, output restart,
		input ready);
	modport sink (input valid, input speed, input turn_rate, input restart,
		output ready);
endinterface

interface uti_pose_if;
	logic              valid;
	logic              ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic [15:0]       heading;
	logic [1:0]        status;

	modport source (output valid, output pos_x, output pos_y, output heading,
		output status, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading,
		input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/unicycle_trajectory_integrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Unicycle pose integrator, one forward-Euler step per command item.
// cmd  (sink):   speed, turn_rate (Q4.12), restart; taken when valid & ready.
// pose (source): pos_x, pos_y (Q8.16), heading (binary angle), status; one item
//                out for every item in.
// cfg:           cfg_we / cfg_index / cfg_data, one register per write, no wait.
//                Write only while the block is idle.
// Sequence: a stepped command runs from accept through a check state, 16 iterations
// of the CORDIC unit (v*dt, w*dt and the heading delta pass through the one 32x32
// multiplier meanwhile), a wait state that picks up the CORDIC result, two more
// multiplier passes for the x and y deltas, then finish, update and output write.
// A rejected command (limit hit or trajectory already failed) goes from the check
// state straight to the output write.
// cmd.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new command is accepted while the last result waits;
// if pose.ready is low when the next result is done, the sequencer holds.
// Reset: pose (0,0,0), failure mark clear, registers at their defaults, no
// result pending.
module unicycle_trajectory_integrator import uti_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	uti_cmd_if.sink                  cmd,
	uti_pose_if.source               pose,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgW-1:0]     cfg_data
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHECK = 11'b000_0000_0010,
		S_VDT   = 11'b000_0000_0100,
		S_WDT   = 11'b000_0000_1000,
		S_HDT   = 11'b000_0001_0000,
		S_WAIT  = 11'b000_0010_0000,
		S_MX    = 11'b000_0100_0000,
		S_MY    = 11'b000_1000_0000,
		S_FIN   = 11'b001_0000_0000,
		S_UPD   = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0]           time_step_q;
	logic [LimW-1:0]       speed_lim_q, turn_lim_q;
	logic [WsW-1:0]        ws_half_q;
	logic signed [PosW-1:0] start_x_q, start_y_q;
	logic [AngW-1:0]       start_h_q;

	// trajectory state
	logic signed [PosW-1:0] pose_x_q, pose_y_q;
	logic [AngW-1:0]       pose_h_q;
	logic                  failed_q;

	// working registers
	logic signed [CmdW-1:0] v_q, w_q;
	logic signed [31:0]    vdt_q, wdt_q;
	logic signed [63:0]    prod_q;
	logic [AngW-1:0]       dh_q;
	logic signed [PosW-1:0] nx_q, ny_q;
	status_t               status_q;

	// output register
	logic                  out_valid_q;
	logic signed [PosW-1:0] out_x_q, out_y_q;
	logic [AngW-1:0]       out_h_q;
	status_t               out_st_q;

	logic cmd_acc, over_lim, cordic_start, out_free;
	logic signed [31:0] mult_a, mult_b;
	logic signed [63:0] mult_p;
	cordic_res_t cordic;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || pose.ready;

	assign over_lim = cmd_over(v_q, speed_lim_q) || cmd_over(w_q, turn_lim_q);
	assign cordic_start = (state_q == S_CHECK) && !failed_q && !over_lim;

	uti_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (pose_h_q),
		.res    (cordic)
	);

	// shared multiplier: v*dt, w*dt, w*dt*k, v*dt*cos, v*dt*sin
	always_comb begin
		mult_a = '0;
		mult_b = '0;
		unique case (state_q)
			S_VDT: begin
				mult_a = {{16{v_q[CmdW-1]}}, v_q};
				mult_b = {16'b0, time_step_q};
			end
			S_WDT: begin
				mult_a = {{16{w_q[CmdW-1]}}, w_q};
				mult_b = {16'b0, time_step_q};
			end
			S_HDT: begin
				mult_a = wdt_q;
				mult_b = RadToBam;
			end
			S_MX: begin
				mult_a = vdt_q;
				mult_b = cordic.cos_v;
			end
			S_MY: begin
				mult_a = vdt_q;
				mult_b = cordic.sin_v;
			end
			S_IDLE, S_CHECK, S_WAIT, S_FIN, S_UPD, S_DONE: begin
				mult_a = '0;
				mult_b = '0;
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
	end

	assign mult_p = mult_a * mult_b;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TimeStepRst;
			speed_lim_q <= SpeedLimRst;
			turn_lim_q  <= TurnLimRst;
			ws_half_q   <= WsHalfRst;
			start_x_q   <= '0;
			start_y_q   <= '0;
			start_h_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIME_STEP:     time_step_q <= cfg_data[15:0];
				REG_SPEED_LIMIT:   speed_lim_q <= cfg_data[LimW-1:0];
				REG_TURN_LIMIT:    turn_lim_q  <= cfg_data[LimW-1:0];
				REG_WS_HALF_WIDTH: ws_half_q   <= cfg_data[WsW-1:0];
				REG_START_X:       start_x_q   <= cfg_data[PosW-1:0];
				REG_START_Y:       start_y_q   <= cfg_data[PosW-1:0];
				REG_START_HEADING: start_h_q   <= cfg_data[AngW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and trajectory state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (cmd.restart) begin
							pose_x_q <= start_x_q;
							pose_y_q <= start_y_q;
							pose_h_q <= start_h_q;
							failed_q <= 1'b0;
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (failed_q) begin
						state_q <= S_DONE;
					end else if (over_lim) begin
						failed_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_VDT;
					end
				end
				S_VDT:  state_q <= S_WDT;
				S_WDT:  state_q <= S_HDT;
				S_HDT:  state_q <= S_WAIT;
				S_WAIT: begin
					if (!cordic.busy) begin
						state_q <= S_MX;
					end
				end
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_FIN;
				S_FIN:  state_q <= S_UPD;
				S_UPD: begin
					if (pos_over(nx_q, ws_half_q) || pos_over(ny_q, ws_half_q)) begin
						failed_q <= 1'b1;
					end else begin
						pose_x_q <= nx_q;
						pose_y_q <= ny_q;
						pose_h_q <= pose_h_q + dh_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			v_q <= cmd.speed;
			w_q <= cmd.turn_rate;
		end
		if (state_q == S_CHECK) begin
			status_q <= failed_q ? ST_FAILED : ST_LIMIT;
		end
		if (state_q == S_VDT) vdt_q <= mult_p[31:0];
		if (state_q == S_WDT) wdt_q <= mult_p[31:0];
		if (state_q == S_HDT || state_q == S_MX || state_q == S_MY) begin
			prod_q <= mult_p;
		end
		// heading delta, rounded at bit 44, only the low 16 bits matter
		if (state_q == S_MX) dh_q <= prod_q[59:44] + {15'b0, prod_q[43]};
		if (state_q == S_MY) nx_q <= pos_step(pose_x_q, prod_q);
		if (state_q == S_FIN) ny_q <= pos_step(pose_y_q, prod_q);
		if (state_q == S_UPD) begin
			status_q <= (pos_over(nx_q, ws_half_q) || pos_over(ny_q, ws_half_q))
				? ST_WORKSPACE : ST_OK;
		end
		if (state_q == S_DONE && out_free) begin
			out_x_q  <= pose_x_q;
			out_y_q  <= pose_y_q;
			out_h_q  <= pose_h_q;
			out_st_q <= status_q;
		end
	end

	assign pose.valid   = out_valid_q;
	assign pose.pos_x   = out_x_q;
	assign pose.pos_y   = out_y_q;
	assign pose.heading = out_h_q;
	assign pose.status  = out_st_q;

	// CORDIC unit is never left running once the sequencer returns to idle
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cordic.busy)
		else $error("CORDIC busy while sequencer idle");

	// pose moves only on a restart at accept or on a successful step
	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_acc && state_q != S_UPD |=> $stable(pose_x_q) && $stable(pose_y_q)
		&& $stable(pose_h_q))
		else $error("pose changed outside an update");

	// failure mark is set only by the limit check or the workspace check
	a_fail_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(failed_q) |-> $past(state_q == S_CHECK || state_q == S_UPD))
		else $error("failure mark set from an unexpected state");

endmodule

`default_nettype wire

FILE: hw/rtl/uti_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module uti_cordic import uti_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] angle,
	output cordic_res_t      res
);

	logic signed [31:0] x_q, y_q, cos_q, sin_q;
	logic signed [32:0] z_q;
	logic [CordicCntW-1:0] cnt_q;
	logic busy_q, flip_q;

	logic signed [31:0] xs, ys, nx, ny;
	logic signed [32:0] nz, at;
	logic [31:0] a_f;
	logic flip;

	// second and third quadrant: turn by half a turn, negate at the end
	assign flip = angle[15] ^ angle[14];
	assign a_f  = {angle, 16'b0} ^ {flip, 31'b0};

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = atan_lut(cnt_q);

	always_comb begin
		if (!z_q[32]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - at;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CordicCntW'(CordicSteps - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CordicStart;
			y_q    <= '0;
			z_q    <= {a_f[31], a_f};
			flip_q <= flip;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
			if (cnt_q == CordicCntW'(CordicSteps - 1)) begin
				cos_q <= flip_q ? -nx : nx;
				sin_q <= flip_q ? -ny : ny;
			end
		end
	end

	assign res.busy  = busy_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

endmodule

`default_nettype wire

FILE: sim/tb_unicycle_trajectory_integrator.sv
`timescale 1ns / 1ps

// Testbench for the unicycle trajectory integrator.
// The directed tests go first. Random traffic follows in three stall mixes.
// Every pose item is checked against a bit-exact model that lives in this file.
module tb_unicycle_trajectory_integrator;
	import uti_pkg::*;

	// Slowest run: about 1100 commands. Either side can add stall to each item, and every
	// setup change adds idle time; this limit leaves a wide margin.
	localparam int CycleLimit = 400000;
	localparam int TailCycles = 40;          // idle cycles after the last pose
	localparam int BlockItems = 84;          // counted items per random setup
	localparam int BlocksPerMix = 4;
	localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 3'd7;

	localparam longint PosMax = 64'sd8388607;
	localparam longint PosMin = -64'sd8388608;
	localparam longint CordicX0 = 64'sd652032874;   // gain-compensated unit vector
	localparam longint BamPerRad = 64'sd683565276;  // 65536/(2*pi), Q.16
	localparam longint PosRound = 64'sd2199023255552;   // 2^41
	localparam longint HdgRound = 64'sd8796093022208;   // 2^43

	typedef struct {
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
		logic [AngW-1:0]        hdg;
		status_t                st;
	} pose_item_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgW-1:0]     cfg_data;

	uti_cmd_if  cmd ();
	uti_pose_if pose ();

	unicycle_trajectory_integrator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pose      (pose),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies as the model sees them
	logic [15:0]            cf_step;
	logic [LimW-1:0]        cf_vlim;
	logic [LimW-1:0]        cf_wlim;
	logic [WsW-1:0]         cf_ws;
	logic signed [PosW-1:0] cf_x0;
	logic signed [PosW-1:0] cf_y0;
	logic [AngW-1:0]        cf_h0;

	// Tracked pose
	logic signed [PosW-1:0] trk_x;
	logic signed [PosW-1:0] trk_y;
	logic [AngW-1:0]        trk_hdg;
	bit                     trk_failed;

	pose_item_t pending_poses[$];
	int         src_idle_pct;
	int         sink_idle_pct;
	int         errors = 0;
	int         poses_checked = 0;
	int         commands_sent;
	int         setups;
	int         cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t: timeout, %0d poses still pending", $time, pending_poses.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Pose side stalls at random
	always @(posedge clk) begin
		pose.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Arc-tangent steps in 2^32-per-turn units
	function automatic longint atan_step(input int i);
		case (i)
			0:       return 64'sh20000000;
			1:       return 64'sh12E4051E;
			2:       return 64'sh09FB385B;
			3:       return 64'sh051111D4;
			4:       return 64'sh028B0D43;
			5:       return 64'sh0145D7E1;
			6:       return 64'sh00A2F61E;
			7:       return 64'sh00517C55;
			8:       return 64'sh0028BE53;
			9:       return 64'sh00145F2F;
			10:      return 64'sh000A2F98;
			11:      return 64'sh000517CC;
			12:      return 64'sh00028BE6;
			13:      return 64'sh000145F3;
			14:      return 64'sh0000A2FA;
			default: return 64'sh0000517D;
		endcase
	endfunction

	// cos/sin of a binary angle in Q2.30. The rotation CORDIC only covers quadrants
	// one and four, so the second and third quadrants are turned by a half turn and
	// the results negated.
	function automatic void heading_unit_vector(input logic [AngW-1:0] hdg,
			output longint c, output longint s);
		logic [31:0] ang;
		bit          flip;
		longint      x, y, z, nx, xs, ys;
		flip = (hdg[15:14] == 2'd1) || (hdg[15:14] == 2'd2);
		ang = {hdg, 16'h0000};
		if (flip) ang[31] = ~ang[31];
		z = longint'($signed(ang));
		x = CordicX0;
		y = 0;
		for (int i = 0; i < CordicSteps; i++) begin
			xs = x >>> i;   // arithmetic shift on a signed value rounds toward -inf
			ys = y >>> i;
			if (z >= 0) begin
				nx = x - ys;
				y = y + xs;
				z = z - atan_step(i);
			end else begin
				nx = x + ys;
				y = y - xs;
				z = z + atan_step(i);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > PosMax) return PosMax;
		if (v < PosMin) return PosMin;
		return v;
	endfunction

	// One Euler step of the tracked pose. Returns the pose item the block must produce.
	function automatic pose_item_t integrate_command(input logic signed [CmdW-1:0] spd,
			input logic signed [CmdW-1:0] trn, input logic rst);
		pose_item_t r;
		longint     v, w, ts, vl, wl, lim, c, s, vdt, wdt, nx, ny, dh;
		v = spd;
		w = trn;
		ts = cf_step;
		vl = cf_vlim;
		wl = cf_wlim;
		lim = cf_ws;
		if (rst) begin
			trk_x = cf_x0;
			trk_y = cf_y0;
			trk_hdg = cf_h0;
			trk_failed = 1'b0;
		end
		if (trk_failed) begin
			r.st = ST_FAILED;
		end else if (magnitude(v) > vl || magnitude(w) > wl) begin
			// -32768 lands here for any limit
			r.st = ST_LIMIT;
			trk_failed = 1'b1;
		end else begin
			heading_unit_vector(trk_hdg, c, s);
			vdt = v * ts;
			wdt = w * ts;
			nx = clamp_pos(longint'(trk_x) + ((vdt * c + PosRound) >>> 42));
			ny = clamp_pos(longint'(trk_y) + ((vdt * s + PosRound) >>> 42));
			dh = (wdt * BamPerRad + HdgRound) >>> 44;
			if (magnitude(nx) > lim || magnitude(ny) > lim) begin
				// pose held at the last valid value
				r.st = ST_WORKSPACE;
				trk_failed = 1'b1;
			end else begin
				r.st = ST_OK;
				trk_x = nx[PosW-1:0];
				trk_y = ny[PosW-1:0];
				trk_hdg = trk_hdg + dh[AngW-1:0];
			end
		end
		r.x = trk_x;
		r.y = trk_y;
		r.hdg = trk_hdg;
		return r;
	endfunction

	// Compare each pose item with the oldest prediction
	always @(posedge clk) begin
		pose_item_t e;
		if (arst_n && pose.valid && pose.ready) begin
			if (pending_poses.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected pose, expected none, got x=%0d y=%0d hdg=%0d st=%0d",
					$time, pose.pos_x, pose.pos_y, pose.heading, pose.status);
			end else begin
				e = pending_poses.pop_front();
				poses_checked <= poses_checked + 1;
				if (pose.pos_x !== e.x || pose.pos_y !== e.y || pose.heading !== e.hdg ||
						pose.status !== e.st) begin
					errors <= errors + 1;
					$display("%0t: pose mismatch, expected x=%0d y=%0d hdg=%0d st=%0d, got x=%0d y=%0d hdg=%0d st=%0d",
						$time, e.x, e.y, e.hdg, e.st,
						pose.pos_x, pose.pos_y, pose.heading, pose.status);
				end
			end
		end
	end

	// Called at a clock edge, returns at the edge that accepts the item. valid stays
	// high so that a back-to-back item needs no second assignment in that step.
	task automatic send_command(input logic signed [CmdW-1:0] spd,
			input logic signed [CmdW-1:0] trn, input logic rst, output pose_item_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.speed <= spd;
		cmd.turn_rate <= trn;
		cmd.restart <= rst;
		do @(posedge clk); while (!cmd.ready);
		p = integrate_command(spd, trn, rst);
		pending_poses = {pending_poses, p};
		commands_sent++;
	endtask

	task automatic send(input logic signed [CmdW-1:0] spd, input logic signed [CmdW-1:0] trn,
			input logic rst);
		pose_item_t p;
		send_command(spd, trn, rst, p);
	endtask

	// Drop valid, wait for every pose, then let the block settle
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// Register write; bits above the register width carry random junk
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val,
			input int w);
		logic [CfgW-1:0] data;
		data = CfgW'($urandom());
		data = (w >= CfgW) ? val : (((data >> w) << w) | val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TIME_STEP:     cf_step = data[15:0];
			REG_SPEED_LIMIT:   cf_vlim = data[LimW-1:0];
			REG_TURN_LIMIT:    cf_wlim = data[LimW-1:0];
			REG_WS_HALF_WIDTH: cf_ws = data[WsW-1:0];
			REG_START_X:       cf_x0 = data[PosW-1:0];
			REG_START_Y:       cf_y0 = data[PosW-1:0];
			REG_START_HEADING: cf_h0 = data[AngW-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send(16'sd0, 16'sd0, 1'b0);
		send(16'sd4096, 16'sd8192, 1'b0);       // exactly at both limits
		send(-16'sd4096, -16'sd8192, 1'b0);
		send(16'sd0, 16'sd0, 1'b1);
	endtask

	task automatic test_command_limits();
		send(16'sd4097, 16'sd0, 1'b0);          // speed one over
		send(16'sd0, 16'sd0, 1'b0);             // ignored, already failed
		send(16'sd0, -16'sd8193, 1'b1);         // turn one over
		send(16'sh8000, 16'sd0, 1'b1);          // most negative speed
		wait_idle();
		write_reg(REG_SPEED_LIMIT, 24'd32767, LimW);
		write_reg(REG_TURN_LIMIT, 24'd32767, LimW);
		write_reg(REG_TIME_STEP, 24'd65535, 16);
		send(16'sd32767, 16'sd32767, 1'b1);
		send(-16'sd32767, -16'sd32767, 1'b0);
		send(16'sd0, 16'sh8000, 1'b0);          // most negative turn at the widest limit
	endtask

	task automatic test_workspace_bounds();
		wait_idle();
		write_reg(REG_WS_HALF_WIDTH, 24'd0, WsW);
		send(16'sd0, 16'sd0, 1'b1);             // origin sits exactly on a zero bound
		send(16'sd4096, 16'sd0, 1'b0);          // any move leaves it
		send(16'sd0, 16'sd0, 1'b0);             // held pose
		wait_idle();
		write_reg(REG_START_X, 24'h7FFFFF, PosW);
		write_reg(REG_START_Y, 24'h800000, PosW);
		write_reg(REG_START_HEADING, 24'h2000, AngW);
		write_reg(REG_WS_HALF_WIDTH, 24'h7FFFFF, WsW);
		send(16'sd4096, 16'sd0, 1'b1);          // x saturates onto the bound
		wait_idle();
		write_reg(REG_START_HEADING, 24'hA000, AngW);
		send(16'sd32767, 16'sd0, 1'b1);         // y saturates to -2^23, one past the bound
		wait_idle();
		write_reg(REG_WS_HALF_WIDTH, 24'd327680, WsW);
		send(16'sd0, 16'sd0, 1'b1);             // start pose loaded outside the square
	endtask

	task automatic test_heading_quadrants();
		logic [AngW-1:0] starts[5];
		starts = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
		wait_idle();
		write_reg(REG_START_X, 24'd0, PosW);
		write_reg(REG_START_Y, 24'd0, PosW);
		write_reg(REG_WS_HALF_WIDTH, 24'h7FFFFF, WsW);
		foreach (starts[i]) begin
			wait_idle();
			write_reg(REG_START_HEADING, {8'h00, starts[i]}, AngW);
			send(16'sd32767, 16'sd32767, 1'b1);  // large turn wraps the heading
		end
		wait_idle();
		write_reg(REG_TIME_STEP, 24'd0, 16);
		send(16'sd32767, -16'sd32767, 1'b0);    // zero step, pose stands still
	endtask

	task automatic test_unmapped_register();
		wait_idle();
		write_reg(REG_TIME_STEP, {8'h00, TimeStepRst}, 16);
		write_reg(REG_UNMAPPED, CfgW'($urandom()), CfgW);
		send(16'sd4096, 16'sd4096, 1'b1);
	endtask

	function automatic logic signed [CmdW-1:0] bounded_cmd(input int lim);
		int mag;
		mag = $urandom_range(lim);
		return CmdW'($urandom_range(1) ? -mag : mag);
	endfunction

	function automatic logic signed [CmdW-1:0] over_cmd(input int lim);
		int mag;
		if (lim == 32767 || $urandom_range(3) == 0) return 16'sh8000;
		mag = $urandom_range(32767, lim + 1);
		return CmdW'($urandom_range(1) ? -mag : mag);
	endfunction

	// New random register set; extremes come up now and then
	task automatic randomize_setup();
		int ws, half, x0, y0, pick;
		pick = $urandom_range(9);
		write_reg(REG_TIME_STEP, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd65535 :
			24'($urandom_range(65535)), 16);
		pick = $urandom_range(9);
		write_reg(REG_SPEED_LIMIT, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd32767 :
			24'($urandom_range(32767)), LimW);
		pick = $urandom_range(9);
		write_reg(REG_TURN_LIMIT, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd32767 :
			24'($urandom_range(32767)), LimW);
		pick = $urandom_range(9);
		if (pick == 0) ws = 0;
		else if (pick == 1) ws = 8388607;
		else if (pick < 5) ws = $urandom_range(1 << 20);
		else ws = $urandom_range(1 << 19, 1 << 16);
		write_reg(REG_WS_HALF_WIDTH, 24'(ws), WsW);
		half = ws / 2;
		if ($urandom_range(7) == 0) begin
			x0 = $urandom();
			y0 = $urandom();
		end else begin
			x0 = int'($urandom_range(2 * half)) - half;
			y0 = int'($urandom_range(2 * half)) - half;
		end
		write_reg(REG_START_X, 24'(x0), PosW);
		write_reg(REG_START_Y, 24'(y0), PosW);
		write_reg(REG_START_HEADING, 24'($urandom_range(65535)), AngW);
		setups++;
	endtask

	// Mostly legal trajectories; a failed one is usually restarted soon. Items that
	// the block answers with the failed status are not counted.
	task automatic test_random_traffic(input int src_pct, input int sink_pct);
		logic signed [CmdW-1:0] spd, trn;
		logic       rst;
		int         kind, done;
		pose_item_t p;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (int b = 0; b < BlocksPerMix; b++) begin
			wait_idle();
			randomize_setup();
			done = 0;
			while (done < BlockItems) begin
				rst = trk_failed ? ($urandom_range(9) < 7) : ($urandom_range(19) == 0);
				kind = $urandom_range(99);
				spd = bounded_cmd(cf_vlim);
				trn = bounded_cmd(cf_wlim);
				if (kind >= 94) begin
					spd = CmdW'($urandom());
					trn = CmdW'($urandom());
				end else if (kind >= 88) begin
					case ($urandom_range(2))
						0: spd = over_cmd(cf_vlim);
						1: trn = over_cmd(cf_wlim);
						default: begin
							spd = over_cmd(cf_vlim);
							trn = over_cmd(cf_wlim);
						end
					endcase
				end
				send_command(spd, trn, rst, p);
				if (p.st != ST_FAILED) done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TIME_STEP;
		cfg_data = '0;
		cmd.valid = 1'b0;
		cmd.speed = '0;
		cmd.turn_rate = '0;
		cmd.restart = 1'b0;
		commands_sent = 0;
		setups = 0;
		src_idle_pct = 19;
		sink_idle_pct = 71;
		// state after reset
		cf_step = TimeStepRst;
		cf_vlim = SpeedLimRst;
		cf_wlim = TurnLimRst;
		cf_ws = WsHalfRst;
		cf_x0 = '0;
		cf_y0 = '0;
		cf_h0 = '0;
		trk_x = '0;
		trk_y = '0;
		trk_hdg = '0;
		trk_failed = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_command_limits();
		test_workspace_bounds();
		test_heading_quadrants();
		test_unmapped_register();
		test_random_traffic(19, 71);
		test_random_traffic(71, 19);
		test_random_traffic(0, 0);
		wait_idle();

		$display("Covered %0d commands over %0d random setups: limits, workspace exits,",
			commands_sent, setups);
		$display("saturation, heading wrap and restarts; %0d poses checked, %0d mismatches",
			poses_checked, errors);
		if (errors == 0 && pending_poses.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/uti_pkg.sv
hw/rtl/uti_if.sv
hw/rtl/uti_cordic.sv
hw/rtl/unicycle_trajectory_integrator.sv
sim/tb_unicycle_trajectory_integrator.sv
